// ----- sv/ps2mct_pkg.sv -----
package ps2mct_pkg;

    // Internal position width: holds any clamp limit up to 1023
    localparam int unsigned POS_W = 10;
    // Width of the signed move arithmetic: position plus or minus a 9-bit delta
    localparam int unsigned SUM_W = POS_W + 2;

    localparam logic [POS_W-1:0] RESET_X = POS_W'(160);
    localparam logic [POS_W-1:0] RESET_Y = POS_W'(100);

    // Byte 0 of a mouse packet
    localparam int unsigned BTN_LEFT_BIT  = 0;
    localparam int unsigned BTN_RIGHT_BIT = 1;
    localparam int unsigned X_SIGN_BIT    = 4;
    localparam int unsigned Y_SIGN_BIT    = 5;

    // Position of the next tagged byte within a packet
    localparam logic [1:0] BYTE_IDX_FIRST  = 2'd0;
    localparam logic [1:0] BYTE_IDX_SECOND = 2'd1;
    localparam logic [1:0] BYTE_IDX_LAST   = 2'd2;

    // Register map (word index taken from paddr[2])
    localparam int unsigned ADDR_W             = 3;
    localparam logic        REG_DRAWING_ENABLE = 1'b0;

    typedef struct packed {
        logic [8:0] cursor_x;
        logic [7:0] cursor_y;
        logic [8:0] line_from_x;
        logic [7:0] line_from_y;
        logic       moved;
        logic       draw_line;
        logic       left_held;
        logic       right_flag;
    } result_t;

endpackage

// ----- sv/ps2_mouse_cursor_tracker.sv -----
// PS/2 mouse cursor tracker. Takes one controller byte per transaction on the
// input channel; bytes with aux_flag low are dropped, and tagged bytes are
// grouped into three-byte mouse packets. Every completed packet yields exactly
// one result transaction: with the right button set it only raises the sticky
// right_flag output; otherwise, when drawing is enabled, the cursor moves by
// the 9-bit signed dx and the inverted dy, clamped to 0..MAX_X and 0..MAX_Y,
// the left button is recorded and draw_line requests a line from line_from to
// cursor while left is held. Sync and overflow bits of byte 0 are not checked.
// Writing the drawing_enable register (byte address 0) clears right_flag;
// write it only while no packet result is outstanding. Rate: one byte per
// cycle while in_stall is low. All packet work is a single add-and-clamp
// pass from the state registers into the result register, or into its skid
// entry while the receiver stalls the output. The result register is backed
// by one skid entry; in_stall rises only while that skid entry is full.
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
#(
    parameter int unsigned MAX_X = 319,
    parameter int unsigned MAX_Y = 199
)
(
    input  logic              clk,
    input  logic              rst_n,

    // Input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              aux_flag,
    input  logic [7:0]        data_byte,

    // Result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [8:0]        cursor_x,
    output logic [7:0]        cursor_y,
    output logic [8:0]        line_from_x,
    output logic [7:0]        line_from_y,
    output logic              moved,
    output logic              draw_line,
    output logic              left_held,
    output logic              right_flag,

    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Clamp limits in the signed move arithmetic
    localparam logic signed [SUM_W-1:0] LIM_X = SUM_W'(MAX_X);
    localparam logic signed [SUM_W-1:0] LIM_Y = SUM_W'(MAX_Y);

    // Packet assembly and cursor state
    logic [1:0]       byte_idx_reg,   byte_idx_next;
    logic [7:0]       first_byte_reg, first_byte_next;
    logic [7:0]       second_byte_reg, second_byte_next;
    logic [POS_W-1:0] pos_x_reg,      pos_x_next;
    logic [POS_W-1:0] pos_y_reg,      pos_y_next;
    logic             left_reg,       left_next;
    logic             right_reg,      right_next;
    logic             draw_en_reg,    draw_en_next;

    // Result register and its skid entry
    logic             out_valid_reg,  out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    result_t          out_data_reg,   out_data_next;
    result_t          skid_data_reg,  skid_data_next;

    logic             in_accept;
    logic             out_pop;
    logic             cfg_wr;
    logic             res_new;
    result_t          res;

    logic signed [SUM_W-1:0] dx;
    logic signed [SUM_W-1:0] dy;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [POS_W-1:0]        clamp_x;
    logic [POS_W-1:0]        clamp_y;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_pop   = out_valid_reg && !out_stall;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DRAWING_ENABLE);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_DRAWING_ENABLE)
        begin
            prdata = {31'd0, draw_en_reg};
        end
    end

    // ------------------------------------------------------------------
    // Move arithmetic: sign-extend the deltas with the byte 0 sign bits,
    // add dx, subtract dy (screen rows grow downward), then clamp.
    // ------------------------------------------------------------------
    assign dx = {{(SUM_W-8){first_byte_reg[X_SIGN_BIT]}}, second_byte_reg};
    assign dy = {{(SUM_W-8){first_byte_reg[Y_SIGN_BIT]}}, data_byte};

    assign sum_x = $signed({2'b00, pos_x_reg}) + dx;
    assign sum_y = $signed({2'b00, pos_y_reg}) - dy;

    always_comb
    begin
        priority if (sum_x < 0)
        begin
            clamp_x = '0;
        end
        else if (sum_x > LIM_X)
        begin
            clamp_x = LIM_X[POS_W-1:0];
        end
        else
        begin
            clamp_x = sum_x[POS_W-1:0];
        end

        priority if (sum_y < 0)
        begin
            clamp_y = '0;
        end
        else if (sum_y > LIM_Y)
        begin
            clamp_y = LIM_Y[POS_W-1:0];
        end
        else
        begin
            clamp_y = sum_y[POS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Packet assembly and state update
    // ------------------------------------------------------------------
    always_comb
    begin
        byte_idx_next    = byte_idx_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        draw_en_next     = draw_en_reg;
        res_new          = 1'b0;
        res              = '0;

        // Drawing enable write; any write to it drops the sticky right click
        if (cfg_wr)
        begin
            draw_en_next = pwdata[0];
            right_next   = 1'b0;
        end

        if (in_accept && aux_flag)
        begin
            unique case (byte_idx_reg)
                BYTE_IDX_FIRST:
                begin
                    first_byte_next = data_byte;
                    byte_idx_next   = BYTE_IDX_SECOND;
                end
                BYTE_IDX_SECOND:
                begin
                    second_byte_next = data_byte;
                    byte_idx_next    = BYTE_IDX_LAST;
                end
                default:
                begin
                    // Last byte of the packet (a stray index of 3 lands here too)
                    byte_idx_next = BYTE_IDX_FIRST;
                    res_new       = 1'b1;
                    res.moved     = 1'b0;
                    res.draw_line = 1'b0;

                    priority if (first_byte_reg[BTN_RIGHT_BIT])
                    begin
                        right_next = 1'b1;
                    end
                    else if (draw_en_reg)
                    begin
                        pos_x_next    = clamp_x;
                        pos_y_next    = clamp_y;
                        left_next     = first_byte_reg[BTN_LEFT_BIT];
                        res.moved     = 1'b1;
                        res.draw_line = first_byte_reg[BTN_LEFT_BIT];
                    end
                    else
                    begin
                        // Drawing disabled: hold position and left state
                    end

                    res.cursor_x    = pos_x_next[8:0];
                    res.cursor_y    = pos_y_next[7:0];
                    res.line_from_x = pos_x_reg[8:0];
                    res.line_from_y = pos_y_reg[7:0];
                    res.left_held   = left_next;
                    res.right_flag  = right_next;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result register with one skid entry behind it
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || out_pop)
        begin
            // Output slot frees up: drain the skid first, else take the new result
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (res_new)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (res_new)
        begin
            // Output held by the receiver: park the new result
            skid_data_next  = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg    <= BYTE_IDX_FIRST;
            first_byte_reg  <= '0;
            second_byte_reg <= '0;
            pos_x_reg       <= RESET_X;
            pos_y_reg       <= RESET_Y;
            left_reg        <= 1'b0;
            right_reg       <= 1'b0;
            draw_en_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_idx_reg    <= byte_idx_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            left_reg        <= left_next;
            right_reg       <= right_next;
            draw_en_reg     <= draw_en_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign cursor_x    = out_data_reg.cursor_x;
    assign cursor_y    = out_data_reg.cursor_y;
    assign line_from_x = out_data_reg.line_from_x;
    assign line_from_y = out_data_reg.line_from_y;
    assign moved       = out_data_reg.moved;
    assign draw_line   = out_data_reg.draw_line;
    assign left_held   = out_data_reg.left_held;
    assign right_flag  = out_data_reg.right_flag;

endmodule

// ----- sv/ps2mct_checker.sv -----
module ps2mct_assert
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [8:0] cursor_x,
    input logic [7:0] cursor_y,
    input logic [8:0] line_from_x,
    input logic [7:0] line_from_y,
    input logic       moved,
    input logic       draw_line,
    input logic       left_held
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_x) && $stable(cursor_y)
            && $stable(moved) && $stable(draw_line))
        else $error("stalled result changed or dropped");

    // No move: line start equals cursor
    a_no_move_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !moved |-> (cursor_x == line_from_x) && (cursor_y == line_from_y))
        else $error("cursor changed without a move");

    // A line request needs a move with left held
    a_line_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && draw_line |-> moved && left_held)
        else $error("line request without move and left button");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_assert u_ps2mct_assert
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cursor_x    (cursor_x),
    .cursor_y    (cursor_y),
    .line_from_x (line_from_x),
    .line_from_y (line_from_y),
    .moved       (moved),
    .draw_line   (draw_line),
    .left_held   (left_held)
);

// ----- verif/ps2mct_checker.sv -----
module ps2mct_checker
    import ps2mct_pkg::*;
#(
    parameter int unsigned MAX_X = 319,
    parameter int unsigned MAX_Y = 199
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              aux_flag,
    input  logic [7:0]        data_byte,

    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [8:0]        cursor_x,
    input  logic [7:0]        cursor_y,
    input  logic [8:0]        line_from_x,
    input  logic [7:0]        line_from_y,
    input  logic              moved,
    input  logic              draw_line,
    input  logic              left_held,
    input  logic              right_flag,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,

    output int                pending,
    output int                errors
);

    localparam logic [ADDR_W-1:0] DRAW_EN_ADDR = {REG_DRAWING_ENABLE, 2'b00};
    localparam int DELTA_SPAN = 256;
    localparam int REPORT_MAX = 10;

    // Mirror of the tracker state
    logic [1:0] pkt_pos;
    logic [7:0] head_byte;
    logic [7:0] dx_byte;
    int         pos_x;
    int         pos_y;
    logic       left_rec;
    logic       right_seen;
    logic       draw_en;
    int         err_cnt;

    result_t cursor_q[$];

    function automatic int clamp_to(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the packet assembler by one tagged byte; return 1 when a packet closes
    function automatic logic absorb_byte(input logic [7:0] b, output result_t r);
        int   dx;
        int   dy;
        int   old_x;
        int   old_y;
        logic mv;
        logic line;
        old_x = pos_x;
        old_y = pos_y;
        mv    = 1'b0;
        line  = 1'b0;
        r     = '0;
        if (pkt_pos == BYTE_IDX_FIRST)
        begin
            head_byte = b;
            pkt_pos   = BYTE_IDX_SECOND;
            return 1'b0;
        end
        if (pkt_pos == BYTE_IDX_SECOND)
        begin
            dx_byte = b;
            pkt_pos = BYTE_IDX_LAST;
            return 1'b0;
        end
        pkt_pos = BYTE_IDX_FIRST;
        if (head_byte[BTN_RIGHT_BIT])
        begin
            right_seen = 1'b1;
        end
        else if (draw_en)
        begin
            dx = int'(dx_byte);
            dy = int'(b);
            if (head_byte[X_SIGN_BIT])
                dx -= DELTA_SPAN;
            if (head_byte[Y_SIGN_BIT])
                dy -= DELTA_SPAN;
            pos_x    = clamp_to(pos_x + dx, int'(MAX_X));
            pos_y    = clamp_to(pos_y - dy, int'(MAX_Y));
            left_rec = head_byte[BTN_LEFT_BIT];
            mv       = 1'b1;
            line     = left_rec;
        end
        r.cursor_x    = 9'(pos_x);
        r.cursor_y    = 8'(pos_y);
        r.line_from_x = 9'(old_x);
        r.line_from_y = 8'(old_y);
        r.moved       = mv;
        r.draw_line   = line;
        r.left_held   = left_rec;
        r.right_flag  = right_seen;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        result_t got;
        logic    bad;
        if (!rst_n)
        begin
            pkt_pos    = BYTE_IDX_FIRST;
            head_byte  = '0;
            dx_byte    = '0;
            pos_x      = int'(RESET_X);
            pos_y      = int'(RESET_Y);
            left_rec   = 1'b0;
            right_seen = 1'b0;
            draw_en    = 1'b0;
            err_cnt    = 0;
            cursor_q.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == DRAW_EN_ADDR)
            begin
                draw_en    = pwdata[0];
                right_seen = 1'b0;
            end

            // Check the result transaction first: it never belongs to this edge's input
            if (out_valid && !out_stall)
            begin
                got.cursor_x    = cursor_x;
                got.cursor_y    = cursor_y;
                got.line_from_x = line_from_x;
                got.line_from_y = line_from_y;
                got.moved       = moved;
                got.draw_line   = draw_line;
                got.left_held   = left_held;
                got.right_flag  = right_flag;
                if (cursor_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX)
                        $display("checker: unexpected result x=%0d y=%0d", cursor_x, cursor_y);
                end
                else
                begin
                    want = cursor_q.pop_front();
                    bad  = (got.cursor_x    !== want.cursor_x)
                        || (got.cursor_y    !== want.cursor_y)
                        || (got.line_from_x !== want.line_from_x)
                        || (got.line_from_y !== want.line_from_y)
                        || (got.moved       !== want.moved)
                        || (got.draw_line   !== want.draw_line)
                        || (got.left_held   !== want.left_held)
                        || (got.right_flag  !== want.right_flag);
                    if (bad)
                    begin
                        err_cnt++;
                        if (err_cnt <= REPORT_MAX)
                        begin
                            $display("checker: exp x=%0d y=%0d fx=%0d fy=%0d m=%b d=%b l=%b r=%b",
                                     want.cursor_x, want.cursor_y, want.line_from_x,
                                     want.line_from_y, want.moved, want.draw_line,
                                     want.left_held, want.right_flag);
                            $display("checker: got x=%0d y=%0d fx=%0d fy=%0d m=%b d=%b l=%b r=%b",
                                     got.cursor_x, got.cursor_y, got.line_from_x,
                                     got.line_from_y, got.moved, got.draw_line,
                                     got.left_held, got.right_flag);
                        end
                    end
                end
            end

            if (in_valid && !in_stall && aux_flag)
            begin
                if (absorb_byte(data_byte, want))
                    cursor_q.push_back(want);
            end

            pending <= cursor_q.size();
            errors  <= err_cnt;
        end
    end

endmodule

// ----- verif/tb.sv -----
// Stimulus and verdict for the PS/2 cursor tracker. The checker beside the
// block watches every transaction, keeps its own copy of the cursor state and
// compares each result; this module only generates traffic, writes the
// drawing-enable register between phases and reports the outcome.
module tb;
    import ps2mct_pkg::*;

    localparam int unsigned MAX_X = 319;
    localparam int unsigned MAX_Y = 199;

    localparam logic [ADDR_W-1:0] DRAW_EN_ADDR = {REG_DRAWING_ENABLE, 2'b00};
    localparam logic DRAW_OFF = 1'b0;
    localparam logic DRAW_ON  = 1'b1;
    localparam logic TAGGED   = 1'b1;
    localparam logic UNTAGGED = 1'b0;

    localparam int IDLE_PCT     = 11;    // chance per cycle of a gap or a stall
    localparam int NOISE_PCT    = 8;     // untagged byte slipped in before a byte
    localparam int SLIP_PCT     = 4;     // stray tagged byte that shifts framing
    localparam int RIGHT_PCT    = 15;    // packets that keep the right button
    localparam int RANDOM_BYTES = 1200;  // tagged bytes in the random part
    localparam int PHASE_PKTS   = 40;    // packets between register writes
    localparam int QUIET_FIRST  = 100;   // packet window with no gaps or stalls
    localparam int QUIET_LAST   = 180;
    localparam int DRAIN_CYCLES = 4;     // settle time after the last result, before a write
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              aux_flag = 1'b0;
    logic [7:0]        data_byte = '0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [8:0]        cursor_x;
    logic [7:0]        cursor_y;
    logic [8:0]        line_from_x;
    logic [7:0]        line_from_y;
    logic              moved;
    logic              draw_line;
    logic              left_held;
    logic              right_flag;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    int pending;
    int errors;
    int cycle_count = 0;
    int tagged_sent = 0;
    bit quiet = 1'b0;

    ps2_mouse_cursor_tracker #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .aux_flag    (aux_flag),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y),
        .line_from_x (line_from_x),
        .line_from_y (line_from_y),
        .moved       (moved),
        .draw_line   (draw_line),
        .left_held   (left_held),
        .right_flag  (right_flag),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ps2mct_checker #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .aux_flag    (aux_flag),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y),
        .line_from_x (line_from_x),
        .line_from_y (line_from_y),
        .moved       (moved),
        .draw_line   (draw_line),
        .left_held   (left_held),
        .right_flag  (right_flag),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .pending     (pending),
        .errors      (errors)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Stall the result channel at random, except inside the quiet window
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: a hung handshake or a lost result ends here
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    // Offer one byte and hold it until the transaction completes. Random gaps
    // go in front, so they fall before first, middle and last packet bytes alike.
    task automatic send_byte(input logic aux, input logic [7:0] b);
        if (!quiet)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        aux_flag  <= aux;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (aux)
            tagged_sent++;
    endtask

    // Tagged byte, sometimes preceded by an untagged one the block must drop
    task automatic send_noisy(input logic [7:0] b);
        if ($urandom_range(99) < NOISE_PCT)
            send_byte(UNTAGGED, 8'($urandom_range(255)));
        send_byte(TAGGED, b);
    endtask

    task automatic send_packet(input logic [7:0] head, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(TAGGED, head);
        send_byte(TAGGED, dx);
        send_byte(TAGGED, dy);
    endtask

    // Drain all results, let the block settle, then do one setup+access write.
    // Upper data bits are random: only bit 0 should matter.
    task automatic write_draw_enable(input logic en);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DRAW_EN_ADDR;
        pwdata  <= {31'($urandom()), en};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Half small deltas so the cursor wanders, half full-range ones to hit the clamps
    task automatic pick_delta(output logic [7:0] mag, output logic neg);
        int v;
        if ($urandom_range(1) == 0)
        begin
            v   = int'($urandom_range(31)) - 16;
            mag = v[7:0];
            neg = (v < 0);
        end
        else
        begin
            mag = 8'($urandom_range(255));
            neg = 1'($urandom_range(1));
        end
    endtask

    initial
    begin
        logic [7:0] head;
        logic [7:0] dxb;
        logic [7:0] dyb;
        logic       neg;
        int         pkt_count;
        int         phase;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Drawing is off after reset: packet yields a result with no move,
        // and an untagged byte inside the packet is dropped
        send_byte(TAGGED, 8'h00);
        send_byte(UNTAGGED, 8'hAA);
        send_byte(TAGGED, 8'h05);
        send_byte(TAGGED, 8'h07);
        // Right button: raise the sticky flag only
        send_packet(8'h02, 8'h11, 8'h22);

        // Enable drawing; the write also clears the right-click flag
        write_draw_enable(DRAW_ON);
        // Largest positive dx with left held: clamp at the right edge
        send_packet(8'h01, 8'hFF, 8'h00);
        // dy of -255: cursor goes down past the bottom and clamps
        send_packet(8'h21, 8'h00, 8'h01);
        // dx of -256 and dy of +255: clamp y at zero (x stays above it), left released
        send_packet(8'h10, 8'h00, 8'hFF);
        // Sync and overflow bits set, left held: must be ignored
        send_packet(8'hCD, 8'h80, 8'h7F);
        // Zero movement: line_from equals the cursor
        send_packet(8'h00, 8'h00, 8'h00);
        // Every bit of byte 0 set, right among them
        send_packet(8'hFF, 8'hFF, 8'hFF);

        // Random packets in phases; every fourth phase runs with drawing off
        tagged_sent = 0;
        pkt_count   = 0;
        phase       = 0;
        while (tagged_sent < RANDOM_BYTES)
        begin
            if (pkt_count % PHASE_PKTS == 0)
            begin
                write_draw_enable((phase % 4 == 3) ? DRAW_OFF : DRAW_ON);
                phase++;
            end
            quiet = (pkt_count >= QUIET_FIRST) && (pkt_count < QUIET_LAST);

            // Now and then knock the packet framing out of step
            if ($urandom_range(99) < SLIP_PCT)
                send_byte(TAGGED, 8'($urandom_range(255)));

            head = 8'($urandom_range(255));
            if ($urandom_range(99) >= RIGHT_PCT)
                head[BTN_RIGHT_BIT] = 1'b0;
            pick_delta(dxb, neg);
            head[X_SIGN_BIT] = neg;
            pick_delta(dyb, neg);
            head[Y_SIGN_BIT] = neg;

            send_noisy(head);
            send_noisy(dxb);
            send_noisy(dyb);
            pkt_count++;
        end
        quiet = 1'b0;

        // Drop valid, wait out every expected result, then a short tail
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
sv/ps2mct_pkg.sv
sv/ps2_mouse_cursor_tracker.sv
sv/ps2mct_checker.sv
verif/ps2mct_checker.sv
verif/tb.sv
